// ===== rtl/rhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  // Channel and result widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 9;
  // Both divisions produce an 8-bit quotient from a 16-bit dividend
  localparam int unsigned QuotW  = 8;
  localparam int unsigned DivdW  = 2 * QuotW;

  // Default number of restoring steps done in one divider stage
  localparam int unsigned STEPS_PER_STAGE = 2;

  // Hexcone constants
  localparam logic [HueW-1:0] DegFull   = 9'd360;
  localparam logic [HueW-1:0] DegGreen  = 9'd120;
  localparam logic [HueW-1:0] DegBlue   = 9'd240;
  localparam logic [HueW-1:0] DegRed    = 9'd0;

  // One restoring divider lane: partial remainder, dividend/quotient shift
  // register and divisor
  typedef struct packed {
    logic [QuotW-1:0] rem;
    logic [QuotW-1:0] dq;
    logic [ChanW-1:0] dvsr;
  } lane_t;

  // Side information carried alongside the two divisions
  typedef struct packed {
    logic [HueW-1:0]  base;   // sector offset in degrees
    logic             neg;    // subtract the sector fraction from base
    logic             flat;   // all channels equal
    logic             black;  // largest channel is zero
    logic [ChanW-1:0] value;  // largest channel
  } side_t;

  // One pixel in flight
  typedef struct packed {
    lane_t sat;
    lane_t hue;
    side_t side;
  } item_t;

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor when it fits and shift in the quotient bit
  function automatic lane_t div_step(input lane_t l);
    lane_t             r;
    logic [QuotW:0]    t;
    logic [QuotW:0]    d;
    r = l;
    t = {l.rem, l.dq[QuotW-1]};
    d = t - {1'b0, l.dvsr};
    if (t >= {1'b0, l.dvsr}) begin
      r.rem = d[QuotW-1:0];
      r.dq  = {l.dq[QuotW-2:0], 1'b1};
    end else begin
      r.rem = t[QuotW-1:0];
      r.dq  = {l.dq[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// RGB to HSV converter, one 8-bit RGB pixel in, one hue/saturation/value
// result out.
// Input channel: in_valid_i with red_i, green_i, blue_i; a transfer happens
// at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with hue_o (0..359 degrees), saturation_o
// (floor(255*delta/max)) and brightness_o (largest channel); a transfer
// happens with out_valid_o high and out_stall_i low.
// Pipeline: one stage finds max, min and the hue sector, the divider
// stages share the two 8-bit restoring divisions (two divider steps per
// stage by default), and one stage assembles and holds the result.
// Throughput is one pixel per clock while out_stall_i is low. Every stage
// has its own valid bit and accepts when empty or when the stage after it
// moves on, so bubbles are squeezed out while the receiver stalls;
// in_stall_o rises only once all stages are full and out_stall_i is high.
// Stalled results stay unchanged.
// Reset clears all valid bits; the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter_unit #(
  parameter int unsigned StepsPerStage = rhc_pkg::STEPS_PER_STAGE
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [rhc_pkg::ChanW-1:0] red_i,
  input  wire logic [rhc_pkg::ChanW-1:0] green_i,
  input  wire logic [rhc_pkg::ChanW-1:0] blue_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [rhc_pkg::HueW-1:0]  hue_o,
  output      logic [rhc_pkg::ChanW-1:0] saturation_o,
  output      logic [rhc_pkg::ChanW-1:0] brightness_o
);
  import rhc_pkg::*;

  localparam int unsigned NumDivStages = QuotW / StepsPerStage;

  // Stage k feeds stage k+1; index 0 is the front stage output
  logic  stg_valid [NumDivStages+1];
  logic  stg_ready [NumDivStages+2];
  item_t stg_item  [NumDivStages+1];

  assign in_stall_o = !stg_ready[0];

  // Sort channels and set up the divisions
  rhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .nxt_ready_i (stg_ready[1]),
    .ready_o     (stg_ready[0]),
    .valid_o     (stg_valid[0]),
    .item_o      (stg_item[0])
  );

  // Divider stages
  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    rhc_div_stage #(
      .Steps (StepsPerStage)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (stg_valid[k]),
      .item_i      (stg_item[k]),
      .nxt_ready_i (stg_ready[k+2]),
      .ready_o     (stg_ready[k+1]),
      .valid_o     (stg_valid[k+1]),
      .item_o      (stg_item[k+1])
    );
  end

  // Assemble and hold the result
  rhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stg_valid[NumDivStages]),
    .item_i       (stg_item[NumDivStages]),
    .out_stall_i  (out_stall_i),
    .ready_o      (stg_ready[NumDivStages+1]),
    .out_valid_o  (out_valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rhc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhc_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [rhc_pkg::ChanW-1:0] red_i,
  input  wire logic [rhc_pkg::ChanW-1:0] green_i,
  input  wire logic [rhc_pkg::ChanW-1:0] blue_i,
  input  wire logic                     nxt_ready_i,
  output      logic                     ready_o,
  output      logic                     valid_o,
  output      rhc_pkg::item_t           item_o
);
  import rhc_pkg::*;

  logic             valid_q;
  item_t            item_d, item_q;
  logic [ChanW-1:0] hi, lo, delta, diff_n;
  logic [DivdW-1:0] sat_divd, hue_divd;
  logic             neg;
  logic [HueW-1:0]  base;

  // Find max, min and the hue sector
  always_comb begin
    hi = (red_i >= green_i) ? red_i : green_i;
    hi = (hi >= blue_i) ? hi : blue_i;
    lo = (red_i <= green_i) ? red_i : green_i;
    lo = (lo <= blue_i) ? lo : blue_i;
    delta = hi - lo;

    if (red_i == hi) begin
      base   = DegRed;
      neg    = (green_i < blue_i);
      diff_n = neg ? (blue_i - green_i) : (green_i - blue_i);
    end else if (green_i == hi) begin
      base   = DegGreen;
      neg    = (blue_i < red_i);
      diff_n = neg ? (red_i - blue_i) : (blue_i - red_i);
    end else begin
      base   = DegBlue;
      neg    = (red_i < green_i);
      diff_n = neg ? (green_i - red_i) : (red_i - green_i);
    end
    // Red sector below zero wraps to the top of the circle
    if (neg && (base == DegRed)) begin
      base = DegFull;
    end
  end

  // Build both dividends: 255 * delta and 60 * |difference|
  always_comb begin
    sat_divd = {delta, {ChanW{1'b0}}} - {{ChanW{1'b0}}, delta};
    hue_divd = ({{(DivdW-ChanW){1'b0}}, diff_n} << 6)
             - ({{(DivdW-ChanW){1'b0}}, diff_n} << 2);

    item_d.sat.rem   = sat_divd[DivdW-1:QuotW];
    item_d.sat.dq    = sat_divd[QuotW-1:0];
    item_d.sat.dvsr  = hi;
    item_d.hue.rem   = hue_divd[DivdW-1:QuotW];
    item_d.hue.dq    = hue_divd[QuotW-1:0];
    item_d.hue.dvsr  = delta;
    item_d.side.base  = base;
    item_d.side.neg   = neg;
    item_d.side.flat  = (delta == '0);
    item_d.side.black = (hi == '0);
    item_d.side.value = hi;
  end

  assign ready_o = !valid_q || nxt_ready_i;

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload on a transfer
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/rhc_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_stage #(
  parameter int unsigned Steps = rhc_pkg::STEPS_PER_STAGE
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire rhc_pkg::item_t item_i,
  input  wire logic           nxt_ready_i,
  output      logic           ready_o,
  output      logic           valid_o,
  output      rhc_pkg::item_t item_o
);
  import rhc_pkg::*;

  logic  valid_q;
  item_t item_d, item_q;

  // Run a few restoring steps on both lanes
  always_comb begin
    item_d = item_i;
    for (int unsigned k = 0; k < Steps; k++) begin
      item_d.sat = div_step(item_d.sat);
      item_d.hue = div_step(item_d.hue);
    end
  end

  assign ready_o = !valid_q || nxt_ready_i;

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload on a transfer
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/rhc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhc_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire rhc_pkg::item_t            item_i,
  input  wire logic                      out_stall_i,
  output      logic                      ready_o,
  output      logic                      out_valid_o,
  output      logic [rhc_pkg::HueW-1:0]  hue_o,
  output      logic [rhc_pkg::ChanW-1:0] saturation_o,
  output      logic [rhc_pkg::ChanW-1:0] brightness_o
);
  import rhc_pkg::*;

  logic             valid_q;
  logic [HueW-1:0]  hue_d, hue_q, frac, ang;
  logic [ChanW-1:0] sat_d, sat_q, bright_q;

  // Combine sector offset with the quotient; round up when subtracting
  always_comb begin
    frac = {{(HueW-QuotW){1'b0}}, item_i.hue.dq};
    if (item_i.side.neg) begin
      ang = item_i.side.base - frac - {{(HueW-1){1'b0}}, (item_i.hue.rem != '0)};
    end else begin
      ang = item_i.side.base + frac;
    end
    if (ang >= DegFull) begin
      ang = ang - DegFull;
    end
    hue_d = item_i.side.flat ? '0 : ang;
    sat_d = item_i.side.black ? '0 : item_i.sat.dq;
  end

  assign ready_o = !valid_q || !out_stall_i;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= item_i.side.value;
    end
  end

  assign out_valid_o  = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

`default_nettype wire
